// File: sv/cwasc_pkg.sv
// shared types and constants for the twelve-hour clock controller
// no dependencies

package cwasc_pkg;

    localparam int unsigned SPM_W = 6;

    localparam logic [SPM_W-1:0] SPM_MIN   = 6'd2;
    localparam logic [SPM_W-1:0] SPM_MAX   = 6'd60;
    localparam logic [SPM_W-1:0] SPM_RESET = 6'd60;

    localparam logic [3:0] HOUR_LAST   = 4'd12;
    localparam logic [3:0] HOUR_FIRST  = 4'd1;
    localparam logic [2:0] TENS_LAST   = 3'd5;
    localparam logic [3:0] ONES_LAST   = 4'd9;
    localparam logic [5:0] ALARM_MIN_LAST = 6'd59;

    typedef enum logic [2:0] {
        MODE_DISPLAY      = 3'd0,
        MODE_SET_HOUR     = 3'd1,
        MODE_SET_MINUTE   = 3'd2,
        MODE_CHIME        = 3'd3,
        MODE_ALARM        = 3'd4,
        MODE_ALARM_HOUR   = 3'd5,
        MODE_ALARM_MINUTE = 3'd6
    } mode_t;

    typedef struct packed {
        logic tick;
        logic mode_button_level;
        logic adjust_button_level;
    } item_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] hours;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
        logic [5:0] seconds;
        logic       is_pm;
        logic       blink_dot;
        logic       show_hours_minutes;
        logic       chime_on;
        logic       alarm_on;
        logic [3:0] alarm_hour;
        logic [5:0] alarm_minute;
    } result_t;

endpackage

// File: sv/cwasc_in_reg.sv
// input register stage for the clock controller
// depends on cwasc_pkg

module cwasc_in_reg import cwasc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  item_t s_item,
    input  logic  item_take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: sv/cwasc_core.sv
// clock state registers and the per-item update logic
// depends on cwasc_pkg

module cwasc_core import cwasc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [SPM_W-1:0] cfg_data,
    input  logic             item_take,
    input  item_t            item,
    output result_t          res_next
);

    logic [SPM_W-1:0] spm_reg;
    logic [1:0]       levels_reg;
    mode_t            mode_reg;
    logic [3:0]       hour_reg;
    logic [2:0]       tens_reg;
    logic [3:0]       ones_reg;
    logic [5:0]       sec_reg;
    logic             pm_reg;
    logic             dot_reg;
    logic             view_reg;
    logic             chime_reg;
    logic             alarm_reg;
    logic [3:0]       alarm_hour_reg;
    logic [5:0]       alarm_min_reg;

    mode_t            mode_next;
    logic [3:0]       hour_next;
    logic [2:0]       tens_next;
    logic [3:0]       ones_next;
    logic [5:0]       sec_next;
    logic             pm_next;
    logic             dot_next;
    logic             view_next;
    logic             chime_next;
    logic             alarm_next;
    logic [3:0]       alarm_hour_next;
    logic [5:0]       alarm_min_next;

    logic [1:0]       levels_in;
    logic [1:0]       falling;
    logic [SPM_W-1:0] limit;
    logic [6:0]       sec_inc;
    logic             min_wrap;

    assign levels_in = {item.adjust_button_level, item.mode_button_level};
    assign falling   = levels_reg & ~levels_in;

    // clamp the register before use
    always_comb begin
        if (spm_reg < SPM_MIN) begin
            limit = SPM_MIN;
        end else if (spm_reg > SPM_MAX) begin
            limit = SPM_MAX;
        end else begin
            limit = spm_reg;
        end
    end

    always_comb begin
        mode_next       = mode_reg;
        hour_next       = hour_reg;
        tens_next       = tens_reg;
        ones_next       = ones_reg;
        sec_next        = sec_reg;
        pm_next         = pm_reg;
        dot_next        = dot_reg;
        view_next       = view_reg;
        chime_next      = chime_reg;
        alarm_next      = alarm_reg;
        alarm_hour_next = alarm_hour_reg;
        alarm_min_next  = alarm_min_reg;
        sec_inc         = 7'd0;
        min_wrap        = 1'b0;

        // mode button first
        if (falling[0]) begin
            if ((mode_reg == MODE_ALARM && !alarm_reg) || mode_reg == MODE_ALARM_MINUTE) begin
                mode_next = MODE_DISPLAY;
            end else begin
                mode_next = mode_t'(mode_reg + 3'd1);
            end
            if (mode_next == MODE_SET_HOUR) begin
                sec_next = 6'd0;
            end
        end

        // then the adjust button, acting on the updated mode
        if (falling[1]) begin
            unique case (mode_next)
                MODE_DISPLAY: view_next = !view_reg;
                MODE_SET_HOUR: begin
                    if (hour_reg >= HOUR_LAST) begin
                        hour_next = HOUR_FIRST;
                        pm_next   = !pm_reg;
                    end else begin
                        hour_next = hour_reg + 4'd1;
                    end
                end
                MODE_SET_MINUTE: begin
                    if (ones_reg >= ONES_LAST) begin
                        ones_next = 4'd0;
                        tens_next = (tens_reg >= TENS_LAST) ? 3'd0 : tens_reg + 3'd1;
                    end else begin
                        ones_next = ones_reg + 4'd1;
                    end
                end
                MODE_CHIME: chime_next = !chime_reg;
                MODE_ALARM: alarm_next = !alarm_reg;
                MODE_ALARM_HOUR: begin
                    alarm_hour_next = (alarm_hour_reg >= HOUR_LAST) ? HOUR_FIRST
                                                                    : alarm_hour_reg + 4'd1;
                end
                MODE_ALARM_MINUTE: begin
                    alarm_min_next = (alarm_min_reg >= ALARM_MIN_LAST) ? 6'd0
                                                                       : alarm_min_reg + 6'd1;
                end
                default: ;
            endcase
        end

        // the tick last; time is frozen while hour or minute is being set
        if (item.tick && mode_next != MODE_SET_HOUR && mode_next != MODE_SET_MINUTE) begin
            dot_next = !dot_reg;
            sec_inc  = {1'b0, sec_next} + 7'd1;
            if (sec_inc >= {1'b0, limit}) begin
                sec_next = 6'd0;
                if (ones_reg >= ONES_LAST) begin
                    ones_next = 4'd0;
                    if (tens_reg >= TENS_LAST) begin
                        tens_next = 3'd0;
                        min_wrap  = 1'b1;
                    end else begin
                        tens_next = tens_reg + 3'd1;
                    end
                end else begin
                    ones_next = ones_reg + 4'd1;
                end
                if (min_wrap) begin
                    if (hour_reg >= HOUR_LAST) begin
                        hour_next = HOUR_FIRST;
                        pm_next   = !pm_reg;
                    end else begin
                        hour_next = hour_reg + 4'd1;
                    end
                end
            end else begin
                sec_next = sec_inc[5:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spm_reg <= SPM_RESET;
        end else if (cfg_we) begin
            spm_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg     <= 2'b11;
            mode_reg       <= MODE_DISPLAY;
            hour_reg       <= HOUR_LAST;
            tens_reg       <= 3'd0;
            ones_reg       <= 4'd0;
            sec_reg        <= 6'd0;
            pm_reg         <= 1'b1;
            dot_reg        <= 1'b0;
            view_reg       <= 1'b1;
            chime_reg      <= 1'b1;
            alarm_reg      <= 1'b1;
            alarm_hour_reg <= HOUR_LAST;
            alarm_min_reg  <= 6'd0;
        end else if (item_take) begin
            levels_reg     <= levels_in;
            mode_reg       <= mode_next;
            hour_reg       <= hour_next;
            tens_reg       <= tens_next;
            ones_reg       <= ones_next;
            sec_reg        <= sec_next;
            pm_reg         <= pm_next;
            dot_reg        <= dot_next;
            view_reg       <= view_next;
            chime_reg      <= chime_next;
            alarm_reg      <= alarm_next;
            alarm_hour_reg <= alarm_hour_next;
            alarm_min_reg  <= alarm_min_next;
        end
    end

    always_comb begin
        res_next.mode               = mode_next;
        res_next.hours              = hour_next;
        res_next.minute_tens        = tens_next;
        res_next.minute_ones        = ones_next;
        res_next.seconds            = sec_next;
        res_next.is_pm              = pm_next;
        res_next.blink_dot          = dot_next;
        res_next.show_hours_minutes = view_next;
        res_next.chime_on           = chime_next;
        res_next.alarm_on           = alarm_next;
        res_next.alarm_hour         = alarm_hour_next;
        res_next.alarm_minute       = alarm_min_next;
    end

endmodule

// File: sv/cwasc_out_reg.sv
// result register stage for the clock controller
// depends on cwasc_pkg

module cwasc_out_reg import cwasc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_load,
    input  result_t res_in,
    output logic    res_free,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign res_free   = !valid_reg || m_ready;
    assign valid_next = res_load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = res_reg;

endmodule

// File: sv/clock_with_alarm_setting_controller.sv
// twelve-hour clock controller with chime and alarm settings
// an accepted item is held in the input register, then its result is loaded into the result register
// when the result register has room; one item per cycle sustained while m_ready stays high
// the update is a single pass of small counter logic between the two registers
// reset (aresetn low, synchronous): 12:00:00 PM, display mode, both stages empty
// depends on cwasc_pkg, cwasc_in_reg, cwasc_core, cwasc_out_reg

module clock_with_alarm_setting_controller import cwasc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [SPM_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_tick,
    input  logic             s_mode_button_level,
    input  logic             s_adjust_button_level,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_mode,
    output logic [3:0]       m_hours,
    output logic [2:0]       m_minute_tens,
    output logic [3:0]       m_minute_ones,
    output logic [5:0]       m_seconds,
    output logic             m_is_pm,
    output logic             m_blink_dot,
    output logic             m_show_hours_minutes,
    output logic             m_chime_on,
    output logic             m_alarm_on,
    output logic [3:0]       m_alarm_hour,
    output logic [5:0]       m_alarm_minute
);

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    logic    res_free;
    result_t res_next;
    result_t res_out;

    assign cfg_ready = 1'b1;

    assign s_item.tick                = s_tick;
    assign s_item.mode_button_level   = s_mode_button_level;
    assign s_item.adjust_button_level = s_adjust_button_level;

    // an item moves on when the result register has room
    assign item_take = item_valid && res_free;

    cwasc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_take  (item_take),
        .item_valid (item_valid),
        .item       (item)
    );

    cwasc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .item_take (item_take),
        .item      (item),
        .res_next  (res_next)
    );

    cwasc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_load (item_take),
        .res_in   (res_next),
        .res_free (res_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .res_out  (res_out)
    );

    assign m_mode               = res_out.mode;
    assign m_hours              = res_out.hours;
    assign m_minute_tens        = res_out.minute_tens;
    assign m_minute_ones        = res_out.minute_ones;
    assign m_seconds            = res_out.seconds;
    assign m_is_pm              = res_out.is_pm;
    assign m_blink_dot          = res_out.blink_dot;
    assign m_show_hours_minutes = res_out.show_hours_minutes;
    assign m_chime_on           = res_out.chime_on;
    assign m_alarm_on           = res_out.alarm_on;
    assign m_alarm_hour         = res_out.alarm_hour;
    assign m_alarm_minute       = res_out.alarm_minute;

`ifndef ASSERT_OFF
    a_take_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        item_take |=> m_valid)
        else $error("item left the input register but no result appeared");

    a_hours_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hours >= HOUR_FIRST && m_hours <= HOUR_LAST &&
                     m_alarm_hour >= HOUR_FIRST && m_alarm_hour <= HOUR_LAST))
        else $error("hour count out of range");

    a_minute_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_minute_tens <= TENS_LAST && m_minute_ones <= ONES_LAST &&
                     m_alarm_minute <= ALARM_MIN_LAST))
        else $error("minute digits out of range");

    a_frozen_seconds: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_take && res_next.mode == MODE_SET_HOUR) |=> (m_seconds == 6'd0))
        else $error("seconds not held at zero while setting the hour");
`endif

endmodule
